### hw/rtl/radix_ascii_digit_converter_unit_macros.svh
// Assertion macros shared by the radix converter RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef RADIX_ASCII_DIGIT_CONVERTER_UNIT_MACROS_SVH
`define RADIX_ASCII_DIGIT_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RADC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RADC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/radc_pkg.sv
// Package for the radix converter: beat types, character constants and the
// digit-to-ASCII mapping. No dependencies.
package radc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int BASE_BITS  = 6;
  localparam int CHAR_BITS  = 7;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO      = 7'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_A         = 7'd65;
  localparam logic [BASE_BITS-1:0] DECIMAL_DIGITS = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_MIN       = 6'd2;
  localparam logic [BASE_BITS-1:0] BASE_MAX       = 6'd36;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [BASE_BITS-1:0]  base;
  } item_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic [BASE_BITS-1:0] digit_value;
    logic                 last_digit;
  } digit_t;

  function automatic logic [CHAR_BITS-1:0] ascii_of(input logic [BASE_BITS-1:0] d);
    logic [BASE_BITS-1:0] letter;
    letter = d - DECIMAL_DIGITS;
    if (d < DECIMAL_DIGITS) begin
      return CHAR_ZERO + {1'b0, d};
    end
    return CHAR_A + {1'b0, letter};
  endfunction

endpackage

### hw/rtl/radix_ascii_digit_converter_unit.sv
// Radix converter top level: value and base in, ASCII digits out, most significant first.
// Each digit costs one pass of the one-bit-per-cycle divider, which pushes it onto a stack;
// the digits are then replayed from the stack through a read state and a load state.
// Reset is synchronous and active high; it empties the queue and returns the engine to idle.
// Depends on radc_pkg, radc_front, radc_queue and radc_back.
module radix_ascii_digit_converter_unit import radc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  item_t  item,
  output logic   digit_valid,
  input  logic   digit_ready,
  output digit_t digit
);

  logic  front_valid;
  logic  front_ready;
  item_t front_job;
  logic  job_valid;
  logic  job_ready;
  item_t job;

  radc_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  radc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(front_valid),
    .push_ready(front_ready),
    .push_data (front_job),
    .pop_valid (job_valid),
    .pop_ready (job_ready),
    .pop_data  (job)
  );

  radc_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job),
    .digit_valid(digit_valid),
    .digit_ready(digit_ready),
    .digit      (digit)
  );

endmodule

### hw/rtl/radc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module radc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/radc_front.sv
// Front end: accepts input beats, masks the value to its working width and
// clamps the base into range. Depends on radc_pkg.
module radc_front import radc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  job_valid,
  input  logic  job_ready,
  output item_t job
);

  localparam int EW = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
  localparam logic [VALUE_BITS-1:0] VALUE_MASK = {VALUE_BITS{1'b1}} >> (VALUE_BITS - EW);

  logic                 valid;
  item_t                data;
  logic [BASE_BITS-1:0] base_sat;

  assign item_ready = !valid || job_ready;
  assign job_valid  = valid;
  assign job        = data;

  always_comb begin
    if (item.base < BASE_MIN) begin
      base_sat = BASE_MIN;
    end else if (item.base > BASE_MAX) begin
      base_sat = BASE_MAX;
    end else begin
      base_sat = item.base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item_ready) begin
      valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      data.value <= item.value & VALUE_MASK;
      data.base  <= base_sat;
    end
  end

endmodule

### hw/rtl/radc_queue.sv
// Two-entry queue that decouples the front end from the conversion engine.
// Depends on radc_pkg.
module radc_queue import radc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_data
);

  item_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### hw/rtl/radc_back.sv
// Conversion engine: bit-serial division by the base, a digit stack in RAM,
// and an output register that replays the stack most significant first.
// Depends on radc_pkg, radc_ram and the assertion macro header.
`include "radix_ascii_digit_converter_unit_macros.svh"

module radc_back import radc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   job_valid,
  output logic   job_ready,
  input  item_t  job,
  output logic   digit_valid,
  input  logic   digit_ready,
  output digit_t digit
);

  localparam int EW = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
  localparam int BW = $clog2(EW);
  localparam int AW = $clog2(VALUE_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIVIDE = 4'b0010,
    S_READ   = 4'b0100,
    S_LOAD   = 4'b1000
  } state_t;

  state_t               state;
  logic [EW-1:0]        dividend;
  logic [BASE_BITS-1:0] base_q;
  logic [BASE_BITS-1:0] rem;
  logic [BW-1:0]        bit_cnt;
  logic [AW-1:0]        dcount;
  logic [AW-1:0]        ptr;
  digit_t               digit_q;

  logic [BASE_BITS:0]   trial;
  logic                 fits;
  logic [BASE_BITS:0]   diff;
  logic [BASE_BITS-1:0] rem_step;
  logic [EW-1:0]        div_step;
  logic                 div_last;
  logic                 ram_we;
  logic [BASE_BITS-1:0] ram_rdata;
  logic                 load;

  assign trial    = {rem, dividend[EW-1]};
  assign fits     = trial >= {1'b0, base_q};
  assign diff     = trial - {1'b0, base_q};
  assign rem_step = fits ? diff[BASE_BITS-1:0] : trial[BASE_BITS-1:0];
  assign div_step = {dividend[EW-2:0], fits};
  assign div_last = (bit_cnt == BW'(EW - 1));
  assign ram_we   = (state == S_DIVIDE) && div_last;
  assign load     = (state == S_LOAD) && (!digit_valid || digit_ready);

  assign job_ready = (state == S_IDLE);
  assign digit     = digit_q;

  radc_ram #(
    .WIDTH(BASE_BITS),
    .DEPTH(VALUE_WIDTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(dcount),
    .wdata(rem_step),
    .raddr(ptr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (div_last && (div_step == '0)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (load) begin
            state <= (ptr == '0) ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (job_valid) begin
          dividend <= job.value[EW-1:0];
          base_q   <= job.base;
          rem      <= '0;
          bit_cnt  <= '0;
          dcount   <= '0;
        end
      end
      S_DIVIDE: begin
        dividend <= div_step;
        if (div_last) begin
          rem     <= '0;
          bit_cnt <= '0;
          if (div_step == '0) begin
            ptr <= dcount;
          end else begin
            dcount <= dcount + AW'(1);
          end
        end else begin
          rem     <= rem_step;
          bit_cnt <= bit_cnt + BW'(1);
        end
      end
      S_LOAD: begin
        if (load && (ptr != '0)) begin
          ptr <= ptr - AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (load) begin
      digit_valid <= 1'b1;
    end else if (digit_ready) begin
      digit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digit_q.digit_char  <= ascii_of(ram_rdata);
      digit_q.digit_value <= ram_rdata;
      digit_q.last_digit  <= (ptr == '0);
    end
  end

  `RADC_ASSERT_IMP(a_rem_below_base, state == S_DIVIDE, rem < base_q, "Remainder reached the base.")
  `RADC_ASSERT_IMP(a_base_in_range, state != S_IDLE, (base_q >= BASE_MIN) && (base_q <= BASE_MAX), "Base out of range.")
  `RADC_ASSERT_NXT(a_last_ends_item, load && (ptr == '0), state == S_IDLE, "Item did not end after its last digit.")

endmodule
